>>> hdl/psr_pkg.sv
package psr_pkg;

    localparam int HALF_TAPS = 16;
    localparam int MAX_UP    = 64;
    localparam int MAX_OUT   = 16;

    localparam int ROW_LEN   = HALF_TAPS + 1;
    localparam int TABLE_LEN = (MAX_UP + 1) * ROW_LEN;
    localparam int ADDR_W    = $clog2(TABLE_LEN);
    localparam int ROW_W     = $clog2(MAX_UP + 1);
    localparam int STEP_W    = $clog2(ROW_LEN);
    localparam int CNT_W     = $clog2(MAX_OUT + 1);

    localparam int SAMP_W     = 16;
    localparam int PROD_W     = 2 * SAMP_W;
    localparam int ACC_W      = PROD_W + $clog2(2 * ROW_LEN) + 1;
    localparam int COEF_IDX_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMP_W-1:0] samp_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic              shift;
        logic              issue;
        logic              clear;
        logic              coef_ok;
        logic [ADDR_W-1:0] raddr;
    } lane_ctrl_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        samp_t             data;
    } coef_wr_t;

endpackage

>>> hdl/psr_lane.sv
module psr_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  psr_pkg::lane_ctrl_t ctrl,
    input  psr_pkg::coef_wr_t   coef_wr,
    input  psr_pkg::samp_t      shift_in_l,
    input  psr_pkg::samp_t      shift_in_r,
    output psr_pkg::samp_t      next_l,
    output psr_pkg::samp_t      next_r,
    output psr_pkg::acc_t       acc_l,
    output psr_pkg::acc_t       acc_r
);
    import psr_pkg::*;

    samp_t win_l_reg [ROW_LEN];
    samp_t win_r_reg [ROW_LEN];
    samp_t coef_mem  [TABLE_LEN];

    samp_t rd_reg;
    samp_t samp_l_reg;
    samp_t samp_r_reg;
    logic  ok1_reg;
    logic  v1_reg;
    logic  v2_reg;
    logic signed [PROD_W-1:0] prod_l_reg;
    logic signed [PROD_W-1:0] prod_r_reg;
    acc_t  acc_l_reg;
    acc_t  acc_r_reg;
    samp_t coef_eff;

    assign next_l = win_l_reg[1];
    assign next_r = win_r_reg[1];
    assign acc_l  = acc_l_reg;
    assign acc_r  = acc_r_reg;

    // shift on a new pair, rotate once per tap so the head is always the current entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROW_LEN; i++) begin
                win_l_reg[i] <= '0;
                win_r_reg[i] <= '0;
            end
        end else if (ctrl.shift || ctrl.issue) begin
            for (int i = 0; i < ROW_LEN - 1; i++) begin
                win_l_reg[i] <= win_l_reg[i+1];
                win_r_reg[i] <= win_r_reg[i+1];
            end
            win_l_reg[ROW_LEN-1] <= ctrl.shift ? shift_in_l : win_l_reg[0];
            win_r_reg[ROW_LEN-1] <= ctrl.shift ? shift_in_r : win_r_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_wr.we) begin
            coef_mem[coef_wr.addr] <= coef_wr.data;
        end
        if (ctrl.issue) begin
            rd_reg <= coef_mem[ctrl.raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ok1_reg <= 1'b0;
        end else begin
            v1_reg  <= ctrl.issue;
            v2_reg  <= v1_reg;
            ok1_reg <= ctrl.coef_ok;
        end
    end

    assign coef_eff = ok1_reg ? rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            samp_l_reg <= win_l_reg[0];
            samp_r_reg <= win_r_reg[0];
        end
        if (v1_reg) begin
            prod_l_reg <= coef_eff * samp_l_reg;
            prod_r_reg <= coef_eff * samp_r_reg;
        end
        if (ctrl.clear) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (v2_reg) begin
            acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
        end
    end

endmodule

>>> hdl/psr_merge.sv
module psr_merge (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  logic           last_in,
    input  psr_pkg::acc_t  a_l,
    input  psr_pkg::acc_t  a_r,
    input  psr_pkg::acc_t  b_l,
    input  psr_pkg::acc_t  b_r,
    input  logic           m_ready,
    output logic           m_valid,
    output psr_pkg::samp_t m_left_out,
    output psr_pkg::samp_t m_right_out,
    output logic           m_last_out,
    output logic           slot_free
);
    import psr_pkg::*;

    localparam acc_t SAT_HI = ACC_W'(32767);
    localparam acc_t SAT_LO = -ACC_W'(32768);

    logic  valid_reg;
    samp_t left_reg;
    samp_t right_reg;
    logic  last_reg;
    acc_t  sum_l;
    acc_t  sum_r;

    // floor shift by 15, then clamp to 16 bits
    function automatic samp_t finish(acc_t s);
        acc_t q;
        q = s >>> 15;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return $signed(q[SAMP_W-1:0]);
    endfunction

    assign sum_l = a_l + b_l;
    assign sum_r = a_r + b_r;

    assign slot_free   = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign m_left_out  = left_reg;
    assign m_right_out = right_reg;
    assign m_last_out  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg  <= finish(sum_l);
            right_reg <= finish(sum_r);
            last_reg  <= last_in;
        end
    end

endmodule

>>> hdl/polyphase_stereo_resampler.sv
// Stereo rational resampler: each sample transfer shifts one left/right pair into a
// 33-pair window and yields zero to 16 filtered pairs, the last one flagged by m_last_out;
// a coefficient transfer writes one Q1.15 tap. Two lanes, one for the older and one for the
// newer half of the window, each with its own copy of the coefficient table, walk the
// taps in parallel one per cycle; each output takes 17 tap reads through one table port
// per lane, the multiply and accumulate registers, setup and hand-off. The result register
// lets the next output be computed while one waits to be taken. up_factor and down_factor
// are written through the cfg port (index 0 and 1); the user must write them only while
// no transfer is in flight, which the block itself does not enforce.
module polyphase_stereo_resampler (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_kind,
    input  logic [psr_pkg::COEF_IDX_W-1:0]     s_coef_index,
    input  psr_pkg::samp_t                     s_coef_value,
    input  psr_pkg::samp_t                     s_left_in,
    input  psr_pkg::samp_t                     s_right_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output psr_pkg::samp_t                     m_left_out,
    output psr_pkg::samp_t                     m_right_out,
    output logic                               m_last_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import psr_pkg::*;

    localparam int UP_W   = 7;
    localparam int DOWN_W = 16;
    localparam int PH_W   = 18;
    localparam int EXT_W  = PH_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_UP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 1'b1;

    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic signed [EXT_W-1:0] PH_HI = EXT_W'(131071);
    localparam logic signed [EXT_W-1:0] PH_LO = -EXT_W'(131072);

    logic [2:0]             state_reg,  state_next;
    logic [STEP_W-1:0]      step_reg,   step_next;
    logic [CNT_W-1:0]       nout_reg,   nout_next;
    logic signed [PH_W-1:0] phase_reg,  phase_next;
    logic [UP_W-1:0]        up_reg;
    logic [DOWN_W-1:0]      down_reg;
    logic [ADDR_W-1:0]      base_a_reg, base_a_next;
    logic [ADDR_W-1:0]      base_b_reg, base_b_next;
    logic                   ok_a_reg,   ok_a_next;
    logic                   ok_b_reg,   ok_b_next;
    logic                   last_reg,   last_next;

    logic                   accept;
    logic                   go;
    logic                   shift;
    logic                   issue;
    logic                   clear;
    logic                   load;
    logic                   slot_free;
    logic signed [EXT_W-1:0] phase_ext;
    logic signed [EXT_W-1:0] row_a;
    logic signed [PH_W-1:0] phase_dec;
    logic signed [PH_W-1:0] phase_inc;

    lane_ctrl_t ctrl_a;
    lane_ctrl_t ctrl_b;
    coef_wr_t   coef_wr;
    samp_t      chain_l;
    samp_t      chain_r;
    acc_t       acc_a_l, acc_a_r, acc_b_l, acc_b_r;

    function automatic logic signed [PH_W-1:0] sat_ph(logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] q;
        q = v;
        if (q > PH_HI) begin
            q = PH_HI;
        end else if (q < PH_LO) begin
            q = PH_LO;
        end
        return $signed(q[PH_W-1:0]);
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign coef_wr.we   = accept && (s_kind == KIND_COEF) && (s_coef_index < TABLE_LEN);
    assign coef_wr.addr = ADDR_W'(s_coef_index);
    assign coef_wr.data = s_coef_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg   <= UP_W'(1);
            down_reg <= DOWN_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_UP:   up_reg   <= cfg_data[UP_W-1:0];
                CFG_DOWN: down_reg <= cfg_data[DOWN_W-1:0];
                default:  ;
            endcase
        end
    end

    // rows for the next output: older half uses U - phase, newer half uses phase
    assign phase_ext = EXT_W'(phase_reg);
    assign row_a     = $signed(EXT_W'(up_reg)) - phase_ext;
    assign phase_dec = sat_ph(phase_ext - $signed(EXT_W'(down_reg)));
    assign phase_inc = sat_ph(phase_ext + $signed(EXT_W'(up_reg)));
    assign go        = !phase_reg[PH_W-1] && (nout_reg < MAX_OUT);

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        nout_next   = nout_reg;
        phase_next  = phase_reg;
        base_a_next = base_a_reg;
        base_b_next = base_b_reg;
        ok_a_next   = ok_a_reg;
        ok_b_next   = ok_b_reg;
        last_next   = last_reg;
        shift       = 1'b0;
        issue       = 1'b0;
        clear       = 1'b0;
        load        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_kind == KIND_SAMPLE)) begin
                    shift      = 1'b1;
                    nout_next  = '0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (go) begin
                    ok_a_next   = !row_a[EXT_W-1] && (row_a <= MAX_UP);
                    ok_b_next   = (phase_reg <= MAX_UP);
                    base_a_next = ADDR_W'(row_a[ROW_W-1:0] * ROW_LEN);
                    base_b_next = ADDR_W'(phase_reg[ROW_W-1:0] * ROW_LEN);
                    last_next   = phase_dec[PH_W-1] || (nout_reg + 1 == MAX_OUT);
                    phase_next  = phase_dec;
                    nout_next   = nout_reg + CNT_W'(1);
                    clear       = 1'b1;
                    step_next   = '0;
                    state_next  = ST_RUN;
                end else begin
                    phase_next  = phase_inc;
                    nout_next   = '0;
                    state_next  = ST_IDLE;
                end
            end
            ST_RUN: begin
                issue = 1'b1;
                if (step_reg == STEP_W'(HALF_TAPS)) begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DRAIN: begin
                if (step_reg == STEP_W'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    load       = 1'b1;
                    state_next = ST_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            nout_reg  <= '0;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            nout_reg  <= nout_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_a_reg <= base_a_next;
        base_b_reg <= base_b_next;
        ok_a_reg   <= ok_a_next;
        ok_b_reg   <= ok_b_next;
        last_reg   <= last_next;
    end

    // older lane walks taps downward, newer lane skips its shared first entry
    always_comb begin
        ctrl_a.shift   = shift;
        ctrl_a.issue   = issue;
        ctrl_a.clear   = clear;
        ctrl_a.coef_ok = ok_a_reg;
        ctrl_a.raddr   = ADDR_W'(base_a_reg + (HALF_TAPS - step_reg));
        ctrl_b.shift   = shift;
        ctrl_b.issue   = issue;
        ctrl_b.clear   = clear;
        ctrl_b.coef_ok = ok_b_reg && (step_reg != '0);
        ctrl_b.raddr   = ADDR_W'(base_b_reg + step_reg - 1);
    end

    psr_lane u_lane_old (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl_a),
        .coef_wr    (coef_wr),
        .shift_in_l (chain_l),
        .shift_in_r (chain_r),
        .next_l     (),
        .next_r     (),
        .acc_l      (acc_a_l),
        .acc_r      (acc_a_r)
    );

    psr_lane u_lane_new (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl_b),
        .coef_wr    (coef_wr),
        .shift_in_l (s_left_in),
        .shift_in_r (s_right_in),
        .next_l     (chain_l),
        .next_r     (chain_r),
        .acc_l      (acc_b_l),
        .acc_r      (acc_b_r)
    );

    psr_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .last_in     (last_reg),
        .a_l         (acc_a_l),
        .a_r         (acc_a_r),
        .b_l         (acc_b_l),
        .b_r         (acc_b_r),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .m_last_out  (m_last_out),
        .slot_free   (slot_free)
    );

endmodule
